@@ design/dmxcd_pkg.sv @@
// dmxcd_pkg: shared widths, register indexes, reset values and the parser-to-store request type
// for the dmx frame receiver with change detection; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dmxcd_pkg;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 16;
    localparam int CHAN_W     = 9;
    localparam int NUM_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_LABEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_NUMBER  = 8'd3;

    // reset values of the registers
    localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd126;
    localparam logic [BYTE_W-1:0] RECEIVE_LABEL_RST = 8'd5;
    localparam logic [BYTE_W-1:0] END_BYTE_RST      = 8'd231;
    localparam logic [NUM_W-1:0]  INPUT_NUMBER_RST  = 16'd0;

    // shadow store lookup issued by the parser for one data word
    typedef struct packed {
        logic               lookup;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  level;
    } dmxcd_req_t;

endpackage

`default_nettype wire

@@ design/dmxcd_parser.sv @@
// dmxcd_parser: frame header state machine and data word counter
// depends on dmxcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmxcd_parser #(
    parameter int CHANNELS = 512
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             accept,
    input  wire [dmxcd_pkg::BYTE_W-1:0]     rx_byte,
    input  wire [dmxcd_pkg::BYTE_W-1:0]     start_byte,
    input  wire [dmxcd_pkg::BYTE_W-1:0]     receive_label,
    input  wire [dmxcd_pkg::BYTE_W-1:0]     end_byte,
    output dmxcd_pkg::dmxcd_req_t           req
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LABEL  = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_STATUS = 3'd4;
    localparam logic [2:0] PH_SCODE  = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;

    logic [2:0]                      phase_reg;
    logic [2:0]                      phase_next;
    logic [dmxcd_pkg::INDEX_W-1:0]   length_reg;
    logic [dmxcd_pkg::INDEX_W-1:0]   length_next;
    logic [dmxcd_pkg::INDEX_W-1:0]   index_reg;
    logic [dmxcd_pkg::INDEX_W-1:0]   index_next;
    logic [dmxcd_pkg::INDEX_W-1:0]   index_inc;
    logic                            is_end;

    assign index_inc = index_reg + dmxcd_pkg::INDEX_W'(1);
    assign is_end    = (rx_byte == end_byte);

    // data word that needs a look at the shadow store
    assign req.lookup = (phase_reg == PH_DATA) && !is_end
                        && (index_reg < dmxcd_pkg::INDEX_W'(CHANNELS));
    assign req.index  = index_reg;
    assign req.level  = rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        index_next  = index_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == start_byte)
                begin
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                phase_next = (rx_byte == receive_label) ? PH_LEN_LO : PH_HUNT;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {rx_byte, length_reg[7:0]};
                phase_next  = PH_STATUS;
            end
            PH_STATUS:
            begin
                phase_next = PH_SCODE;
            end
            PH_SCODE:
            begin
                index_next = '0;
                phase_next = (length_reg == '0) ? PH_HUNT : PH_DATA;
            end
            PH_DATA:
            begin
                if (is_end)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    index_next = index_inc;
                    if (index_inc >= length_reg)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            length_reg <= '0;
            index_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            index_reg  <= index_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dmx_frame_receiver_change_detect.sv @@
// dmx_frame_receiver_change_detect: top level, config registers, shadow store
// and result register; depends on dmxcd_pkg and dmxcd_parser
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+------------------------------------
// input     | in_valid / in_ready    | rx_byte
// result    | out_valid / out_ready  | source_input, channel, level
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word per cycle while results are taken; a changed channel raises out_valid
// after the store read at accept and the compare into the result register
// the shadow store is a ram with one read and one write per cycle; a fill count
// marks how far it has been written since reset and entries past it read as zero
// the input stalls while a lookup waits behind a result that is not taken yet;
// cfg_ready is always high

module dmx_frame_receiver_change_detect #(
    parameter int CHANNELS = 512
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire [dmxcd_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [dmxcd_pkg::NUM_W-1:0]        source_input,
    output logic [dmxcd_pkg::CHAN_W-1:0]       channel,
    output logic [dmxcd_pkg::BYTE_W-1:0]       level,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [dmxcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [dmxcd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW     = $clog2(CHANNELS);
    localparam int FILL_W = $clog2(CHANNELS + 1);

    // configuration registers
    logic [dmxcd_pkg::BYTE_W-1:0]   start_byte_reg;
    logic [dmxcd_pkg::BYTE_W-1:0]   receive_label_reg;
    logic [dmxcd_pkg::BYTE_W-1:0]   end_byte_reg;
    logic [dmxcd_pkg::NUM_W-1:0]    input_number_reg;

    // parser side
    logic                           in_accept;
    dmxcd_pkg::dmxcd_req_t          req;

    // lookup stage, waits on the ram read
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [AW-1:0]                  s1_addr_reg;
    logic [dmxcd_pkg::CHAN_W-1:0]   s1_chan_reg;
    logic [dmxcd_pkg::BYTE_W-1:0]   s1_level_reg;
    logic                           s1_go;

    // shadow store
    logic [dmxcd_pkg::BYTE_W-1:0]   shadow_mem [CHANNELS];
    logic [dmxcd_pkg::BYTE_W-1:0]   rd_data_reg;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              fill_next;
    logic                           entry_valid;
    logic [dmxcd_pkg::BYTE_W-1:0]   stored;
    logic                           changed;

    // result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [dmxcd_pkg::NUM_W-1:0]    source_input_reg;
    logic [dmxcd_pkg::CHAN_W-1:0]   channel_reg;
    logic [dmxcd_pkg::BYTE_W-1:0]   level_reg;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg    <= dmxcd_pkg::START_BYTE_RST;
            receive_label_reg <= dmxcd_pkg::RECEIVE_LABEL_RST;
            end_byte_reg      <= dmxcd_pkg::END_BYTE_RST;
            input_number_reg  <= dmxcd_pkg::INPUT_NUMBER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dmxcd_pkg::REG_START_BYTE:    start_byte_reg    <= cfg_data[7:0];
                dmxcd_pkg::REG_RECEIVE_LABEL: receive_label_reg <= cfg_data[7:0];
                dmxcd_pkg::REG_END_BYTE:      end_byte_reg      <= cfg_data[7:0];
                dmxcd_pkg::REG_INPUT_NUMBER:  input_number_reg  <= cfg_data;
                default:
                begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // frame parser
    // ---------------------------------------------------------------
    // lookup stage moves on when the result slot is free or being emptied
    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_accept = in_valid && in_ready;

    dmxcd_parser #(
        .CHANNELS      (CHANNELS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .rx_byte       (rx_byte),
        .start_byte    (start_byte_reg),
        .receive_label (receive_label_reg),
        .end_byte      (end_byte_reg),
        .req           (req)
    );

    // ---------------------------------------------------------------
    // shadow store: read at accept; the lookup stage does the compare and write later
    // ---------------------------------------------------------------
    assign rd_en   = in_accept && req.lookup;
    assign rd_addr = req.index[AW-1:0];

    // entries at or past the fill count were never written and read as zero
    assign entry_valid = (FILL_W'(s1_addr_reg) < fill_reg);
    assign stored      = entry_valid ? rd_data_reg : '0;
    assign changed     = (stored != s1_level_reg);

    // an unwritten entry is always written so the fill count can grow;
    // indexes within a frame run up from zero, so the store fills in order
    assign wr_en = s1_go && (changed || !entry_valid);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shadow_mem[s1_addr_reg] <= s1_level_reg;
        end
        if (rd_en)
        begin
            // forward a write to the same entry in the same cycle
            if (wr_en && (s1_addr_reg == rd_addr))
            begin
                rd_data_reg <= s1_level_reg;
            end
            else
            begin
                rd_data_reg <= shadow_mem[rd_addr];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (FILL_W'(s1_addr_reg) == fill_reg))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_addr_reg  <= rd_addr;
            s1_chan_reg  <= req.index[dmxcd_pkg::CHAN_W-1:0];
            s1_level_reg <= req.level;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && changed)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && changed)
        begin
            source_input_reg <= input_number_reg;
            channel_reg      <= s1_chan_reg;
            level_reg        <= s1_level_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_input = source_input_reg;
    assign channel      = channel_reg;
    assign level        = level_reg;

endmodule

`default_nettype wire

@@ design/dmxcd_checker.sv @@
// dmxcd_checker: port-level assertions for the frame receiver, bound to the top
// depends on dmx_frame_receiver_change_detect and dmxcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmxcd_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire                                in_ready,
    input  wire                                out_valid,
    input  wire                                out_ready,
    input  wire [dmxcd_pkg::NUM_W-1:0]         source_input,
    input  wire [dmxcd_pkg::CHAN_W-1:0]        channel,
    input  wire [dmxcd_pkg::BYTE_W-1:0]        level
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(source_input) && $stable(channel)
                                    && $stable(level))
        else $error("result payload changed while stalled");

    // a fresh result comes from a word taken ahead of the lookup stage and result register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input word");

    // input back-pressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with the result side free");

endmodule

bind dmx_frame_receiver_change_detect dmxcd_checker u_dmxcd_checker (.*);

`default_nettype wire
